// ===== rtl/mgsp_pkg.sv =====
// Shared types and constants of the multi-granularity stride prefetcher.
package mgsp_pkg;

    // Learning granularity: one line, sixteen lines or 256 lines.
    typedef enum logic [1:0] {
        MODE_FINE   = 2'd0,
        MODE_MIDDLE = 2'd1,
        MODE_COARSE = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TABLE_ENTRIES     = 3'd0,
        CFG_PREFETCH_DEGREE   = 3'd1,
        CFG_CONFIRM_THRESHOLD = 3'd2,
        CFG_RUN_LIMIT         = 3'd3,
        CFG_FINE_DELTA_LIMIT  = 3'd4,
        CFG_MIDDLE_DELTA_LIMIT = 3'd5
    } t_cfg_reg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned TAG_W       = 12;
    localparam int unsigned OFF_W       = 6;
    localparam int unsigned STRIDE_W    = 7;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned BITMAP_W    = 16;
    localparam int unsigned RUN_W       = 17;
    localparam int unsigned PO_W        = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
    localparam logic [RUN_W-1:0]   RUN_MAX   = 17'h1ffff;
    localparam logic [2:0]         DEGREE_MAX = 3'd4;

    // Payload of one tracker table entry (the valid bit lives beside it).
    typedef struct packed {
        logic [TAG_W-1:0]           tag;
        logic [OFF_W-1:0]           last_off;
        logic signed [STRIDE_W-1:0] stride;
        logic [COUNT_W-1:0]         count;
        logic [BITMAP_W-1:0]        bitmap;
    } t_entry;

    // One prefetch burst handed from the table to the emitter.
    typedef struct packed {
        t_mode                      mode;
        logic signed [PO_W-1:0]     po;
        logic signed [STRIDE_W-1:0] stride;
        logic [2:0]                 steps_left;
        logic [BITMAP_W-1:0]        bitmap;
    } t_job;

endpackage

// ===== rtl/mgsp_req_if.sv =====
// Demand address channel.
interface mgsp_req_if #(parameter int ADDR_BITS = 48);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] address;
    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

// ===== rtl/mgsp_pf_if.sv =====
// Prefetch address channel.
interface mgsp_pf_if #(parameter int ADDR_BITS = 48);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] prefetch_address;
    logic                 last_of_run;
    modport source (output valid, output prefetch_address, output last_of_run, input ready);
    modport sink   (input valid, input prefetch_address, input last_of_run, output ready);
endinterface

// ===== rtl/mgsp_cfg_if.sv =====
// Configuration write channel.
interface mgsp_cfg_if;
    import mgsp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mgsp_cell.sv =====
// One tracker table cell; cells form a recency-ordered shift chain.
module mgsp_cell import mgsp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic             i_prev_valid,
    input  t_entry           i_prev,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output t_entry           o_entry,
    output logic             o_hit
);

    logic   r_valid;
    t_entry r_entry;

    // Valid bit is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= i_prev_valid;
        end
    end

    // Entry payload follows its neighbour when the chain moves.
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_entry <= i_prev;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_hit   = r_valid && (r_entry.tag == i_tag);

endmodule

// ===== rtl/mgsp_emit.sv =====
// Prefetch burst sequencer: one prefetch address per cycle while i_go is high.
module mgsp_emit import mgsp_pkg::*; #(
    parameter int ADDR_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_job                 i_job,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic                 i_go,
    output logic                 o_busy,
    output logic                 o_fire,
    output logic [ADDR_BITS-1:0] o_addr,
    output logic                 o_last
);

    logic                 r_busy;
    t_job                 r_job;
    logic [BITMAP_W-1:0]  r_mask;
    logic [ADDR_BITS-1:0] r_addr;

    logic [3:0]             low_idx;
    logic [BITMAP_W-1:0]    low_bit;
    logic [BITMAP_W-1:0]    rem_mask;
    logic signed [PO_W-1:0] next_po;
    logic                   last_step;
    logic                   step_done;

    // Lowest remaining sub-block of the current step.
    always_comb begin
        low_idx = 4'd0;
        for (int b = BITMAP_W - 1; b >= 0; b--) begin
            if (r_mask[b]) begin
                low_idx = 4'(b);
            end
        end
        low_bit  = BITMAP_W'(1) << low_idx;
        rem_mask = r_mask & ~low_bit;
    end

    // Step bookkeeping: the burst stops at the last step or when the offset leaves its range.
    assign next_po   = r_job.po + PO_W'(r_job.stride);
    assign last_step = (r_job.steps_left == 3'd0) || next_po[PO_W-1] || (next_po[7:6] != 2'b00);
    assign step_done = (r_job.mode == MODE_FINE) || (rem_mask == '0);

    assign o_busy = r_busy;
    assign o_fire = r_busy && i_go;
    assign o_last = step_done && last_step;

    // Address composition for the current step and sub-block.
    always_comb begin
        case (r_job.mode)
            MODE_MIDDLE: o_addr = {r_addr[ADDR_BITS-1:16], r_job.po[5:0], low_idx, 6'b0};
            MODE_COARSE: o_addr = {r_addr[ADDR_BITS-1:20], r_job.po[5:0], low_idx, 10'b0};
            default:     o_addr = {r_addr[ADDR_BITS-1:12], r_job.po[5:0], 6'b0};
        endcase
    end

    // Burst state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_job  <= i_job;
            r_mask <= i_job.bitmap;
            r_addr <= i_addr;
        end else if (o_fire) begin
            if (step_done) begin
                if (last_step) begin
                    r_busy <= 1'b0;
                end
                r_job.po         <= next_po;
                r_job.steps_left <= r_job.steps_left - 3'd1;
                r_mask           <= r_job.bitmap;
            end else begin
                r_mask <= rem_mask;
            end
        end
    end

endmodule

// ===== rtl/multi_granularity_stride_prefetcher_core.sv =====
// Top level of the multi-granularity stride prefetcher.
//
// Demand byte addresses enter on i_req; prefetch byte addresses leave on o_pf,
// with last_of_run set on the final address caused by one demand word.
// Registers are written on i_cfg (index, data); the user must write them only while
// the block is idle, which the block does not enforce. The write channel is always ready.
// Each demand word passes inside through the step that takes it, the granularity
// choice and offset extraction, and the lookup and update of the tracker table,
// which is a recency-ordered chain of cells where a hit or a new entry moves to
// the front and the cells above it shift back by one. A triggered prefetch then
// produces one address per cycle while the receiver is not stalling, up to 64,
// from the burst sequencer, which the lookup starts; its addresses are
// registered in the output register.
// The next demand word is taken as soon as the burst is issued, while its
// final address may still wait in the output register.
// Reset clears all entries, the history and the registers to their defaults.
// A stalled receiver holds the output register and the sequencer.
module multi_granularity_stride_prefetcher_core import mgsp_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int ADDR_BITS   = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mgsp_cfg_if.sink        i_cfg,
    mgsp_req_if.sink        i_req,
    mgsp_pf_if.source       o_pf
);

    localparam int LINE_W = ADDR_BITS - 6;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_GRAN, S_LOOK} t_state;

    // Configuration registers.
    logic [4:0]  r_table_entries;
    logic [2:0]  r_degree;
    logic [3:0]  r_threshold;
    logic [15:0] r_run_limit;
    logic [11:0] r_fine_lim;
    logic [11:0] r_mid_lim;

    t_state               r_state;
    logic [ADDR_BITS-1:0] r_addr;
    logic [LINE_W-1:0]    r_line;
    logic [LINE_W-1:0]    r_pdelta;
    logic [RUN_W-1:0]     r_fine_run;
    logic [RUN_W-1:0]     r_mid_run;
    t_mode                r_mode;
    logic [TAG_W-1:0]     r_tag;
    logic [OFF_W-1:0]     r_off;
    logic [BITMAP_W-1:0]  r_sub;
    logic [CNT_W-1:0]     r_used;

    logic                 r_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic                 r_out_last;

    logic                 emit_busy;
    logic                 emit_fire;
    logic [ADDR_BITS-1:0] emit_addr;
    logic                 emit_last;
    logic                 emit_start;
    t_job                 job;

    // Configuration writes.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_entries <= 5'd16;
            r_degree        <= 3'd4;
            r_threshold     <= 4'd2;
            r_run_limit     <= 16'd8;
            r_fine_lim      <= 12'd2;
            r_mid_lim       <= 12'd16;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TABLE_ENTRIES:      r_table_entries <= i_cfg.data[4:0];
                CFG_PREFETCH_DEGREE:    r_degree        <= i_cfg.data[2:0];
                CFG_CONFIRM_THRESHOLD:  r_threshold     <= i_cfg.data[3:0];
                CFG_RUN_LIMIT:          r_run_limit     <= i_cfg.data;
                CFG_FINE_DELTA_LIMIT:   r_fine_lim      <= i_cfg.data[11:0];
                CFG_MIDDLE_DELTA_LIMIT: r_mid_lim       <= i_cfg.data[11:0];
                default: ;
            endcase
        end
    end

    // Granularity choice from the absolute line delta.
    logic [LINE_W-1:0]   line, delta;
    logic                fine_hit, mid_hit;
    logic [RUN_W-1:0]    n_fine_run, n_mid_run;
    t_mode               n_mode;
    logic [OFF_W-1:0]    n_off;
    logic [BITMAP_W-1:0] n_sub;

    always_comb begin
        line       = r_addr[ADDR_BITS-1:6];
        delta      = (line >= r_line) ? (line - r_line) : (r_line - line);
        fine_hit   = (delta < LINE_W'(r_fine_lim)) && (r_pdelta < LINE_W'(r_fine_lim));
        mid_hit    = (delta < LINE_W'(r_mid_lim)) && (r_pdelta < LINE_W'(r_mid_lim));
        n_fine_run = r_fine_run;
        n_mid_run  = r_mid_run;
        n_mode     = r_mode;
        if (fine_hit) begin
            if (r_fine_run != RUN_MAX) n_fine_run = r_fine_run + RUN_W'(1);
            if (n_fine_run > RUN_W'(r_run_limit)) n_mode = MODE_FINE;
        end else if (mid_hit) begin
            if (r_mid_run != RUN_MAX) n_mid_run = r_mid_run + RUN_W'(1);
            if (n_mid_run > RUN_W'(r_run_limit)) n_mode = MODE_MIDDLE;
        end else begin
            n_mode = MODE_COARSE;
        end
        case (n_mode)
            MODE_MIDDLE: begin
                n_off = r_addr[15:10];
                n_sub = BITMAP_W'(1) << r_addr[9:6];
            end
            MODE_COARSE: begin
                n_off = r_addr[19:14];
                n_sub = BITMAP_W'(1) << r_addr[13:10];
            end
            default: begin
                n_off = r_addr[11:6];
                n_sub = '0;
            end
        endcase
    end

    // Sequencer of the two internal steps.
    assign i_req.ready = (r_state == S_IDLE) && !emit_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_line     <= '0;
            r_pdelta   <= '0;
            r_fine_run <= '0;
            r_mid_run  <= '0;
            r_mode     <= MODE_FINE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_addr  <= i_req.address;
                        r_state <= S_GRAN;
                    end
                end
                S_GRAN: begin
                    r_line     <= line;
                    r_pdelta   <= delta;
                    r_fine_run <= n_fine_run;
                    r_mid_run  <= n_mid_run;
                    r_mode     <= n_mode;
                    r_tag      <= r_addr[19:8];
                    r_off      <= n_off;
                    r_sub      <= n_sub;
                    r_state    <= S_LOOK;
                end
                S_LOOK: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Tracker table chain.
    logic [TABLE_DEPTH-1:0] cell_valid, cell_hit, cell_take;
    t_entry                 cell_entry [TABLE_DEPTH];
    t_entry                 hit_entry, front;
    logic [CNT_W-1:0]       hit_pos, last_take, limit;
    logic                   any_hit, evict, same, trig;
    logic signed [STRIDE_W-1:0] new_stride;
    logic [2:0]             deg_eff;

    always_comb begin
        hit_pos   = '0;
        hit_entry = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (cell_hit[i]) begin
                hit_pos   = hit_pos | CNT_W'(i);
                hit_entry = hit_entry | cell_entry[i];
            end
        end
        any_hit = (cell_hit != '0);

        if (r_table_entries == 5'd0) limit = CNT_W'(1);
        else if (32'(r_table_entries) > 32'(TABLE_DEPTH)) limit = CNT_W'(TABLE_DEPTH);
        else limit = CNT_W'(r_table_entries);
        evict = (r_used >= limit);

        new_stride = STRIDE_W'($signed({1'b0, r_off})) -
                     STRIDE_W'($signed({1'b0, hit_entry.last_off}));
        same = (new_stride == hit_entry.stride);
        trig = any_hit && same && (hit_entry.count > r_threshold);

        if (any_hit) begin
            front.tag      = r_tag;
            front.last_off = r_off;
            front.bitmap   = hit_entry.bitmap | r_sub;
            front.stride   = same ? hit_entry.stride : new_stride;
            if (trig) front.count = hit_entry.count;
            else if (same) front.count = (hit_entry.count == COUNT_MAX) ?
                                         COUNT_MAX : hit_entry.count + COUNT_W'(1);
            else front.count = COUNT_W'(1);
            last_take = hit_pos;
        end else begin
            front.tag      = r_tag;
            front.last_off = r_off;
            front.bitmap   = r_sub;
            front.stride   = '0;
            front.count    = COUNT_W'(1);
            last_take      = evict ? r_used - CNT_W'(1) : r_used;
        end

        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_take[i] = (r_state == S_LOOK) && (CNT_W'(i) <= last_take);
        end

        deg_eff         = (r_degree > DEGREE_MAX) ? DEGREE_MAX : r_degree;
        emit_start      = (r_state == S_LOOK) && trig && (deg_eff != 3'd0);
        job.mode        = r_mode;
        job.po          = PO_W'(r_off);
        job.stride      = new_stride;
        job.steps_left  = deg_eff - 3'd1;
        job.bitmap      = front.bitmap;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        mgsp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_take       (cell_take[g]),
            .i_prev_valid ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g - 1]),
            .i_prev       ((g == 0) ? front : cell_entry[(g == 0) ? 0 : g - 1]),
            .i_tag        (r_tag),
            .o_valid      (cell_valid[g]),
            .o_entry      (cell_entry[g]),
            .o_hit        (cell_hit[g])
        );
    end

    // Fill count of the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if ((r_state == S_LOOK) && !any_hit && !evict) begin
            r_used <= r_used + CNT_W'(1);
        end
    end

    // Burst sequencer and output register.
    mgsp_emit #(.ADDR_BITS(ADDR_BITS)) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (emit_start),
        .i_job   (job),
        .i_addr  (r_addr),
        .i_go    (!r_out_valid || o_pf.ready),
        .o_busy  (emit_busy),
        .o_fire  (emit_fire),
        .o_addr  (emit_addr),
        .o_last  (emit_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
            r_out_addr  <= emit_addr;
            r_out_last  <= emit_last;
        end else if (o_pf.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pf.valid            = r_out_valid;
    assign o_pf.prefetch_address = r_out_addr;
    assign o_pf.last_of_run      = r_out_last;

    // The fill count never exceeds the table.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= TABLE_DEPTH)
        else $error("fill count beyond table depth");

    // Valid cells form an unbroken run from the front of the chain.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid + TABLE_DEPTH'(1)) & cell_valid) == '0)
        else $error("gap in tracker chain");

    // The fill count matches the number of valid cells.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(cell_valid)) == 32'(r_used))
        else $error("fill count disagrees with valid cells");

endmodule
